>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define OGOM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// check that a condition in one cycle implies another in the next
`define OGOM_ASSERT_NEXT(lbl, ante, cons, msg) \
	`OGOM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/ogom_pkg.sv
package ogom_pkg;

	localparam int GRID_CELLS = 65536;
	localparam int GRID_AW    = $clog2(GRID_CELLS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_COST = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OCC_MARK    = 3'd6;

	localparam logic [23:0]        SCALE_RST  = 24'd65536;
	localparam logic [8:0]         DIM_RST    = 9'd256;
	localparam logic signed [7:0]  THRESH_RST = 8'sd65;
	localparam logic signed [7:0]  MARK_RST   = 8'sd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_BND,
		ST_FLAT,
		ST_RD,
		ST_CHK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [7:0] read_value;
		logic              marked;
		logic              skipped;
		logic              frame_changed;
	} res_t;

endpackage

>>> hw/rtl/ogom_if.sv
interface ogom_item_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic signed [7:0] cell_value;
	logic [15:0]       global_index;
	logic [7:0]        cost_col;
	logic [7:0]        cost_row;
	logic              last;

	modport source (output valid, op, cell_value, global_index, cost_col, cost_row, last,
		input ready);
	modport sink (input valid, op, cell_value, global_index, cost_col, cost_row, last,
		output ready);
endinterface

interface ogom_res_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] read_value;
	logic              marked;
	logic              skipped;
	logic              frame_changed;

	modport source (output valid, read_value, marked, skipped, frame_changed, input ready);
	modport sink (input valid, read_value, marked, skipped, frame_changed, output ready);
endinterface

interface ogom_cfg_if import ogom_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/occupancy_grid_obstacle_merge_top.sv
// Load, skipped and unused-op words go from idle straight to the output state; reads pass
// the read and check states; costmap cells run the multiply / add / bound / address /
// memory read / modify-write sequence on the grid memory first. One word in flight: the
// next word is taken only once the result is registered and the sequencer is back in idle;
// a stalled result side holds it in the output state. Reset: asynchronous; clears the
// sequencer, map-loaded, frame and result-valid flags and loads the config reset values.
module occupancy_grid_obstacle_merge_top import ogom_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	ogom_item_if.sink  item,
	ogom_res_if.source res,
	ogom_cfg_if.sink   cfg
);

	typedef struct packed {
		logic       hit;
		logic [8:0] coord;
	} proj_t;

	function automatic proj_t project(logic [34:0] s, logic [8:0] limit);
		proj_t       p;
		logic [16:0] q;
		q = s[33:17];
		if (s[34]) begin
			p.hit   = (&s[34:17]) && (|s[16:0]) && (limit != 9'd0);
			p.coord = 9'd0;
		end else begin
			p.hit   = q < {8'd0, limit};
			p.coord = q[8:0];
		end
		return p;
	endfunction

	state_t state_q, state_d;

	logic signed [31:0] xoff_q, yoff_q;
	logic [23:0]        scale_q;
	logic [8:0]         width_q, height_q;
	logic signed [7:0]  thr_q, mark_q;

	logic [1:0]         op_q;
	logic signed [7:0]  val_q;
	logic               last_q;
	logic [7:0]         col_q, row_q;
	logic [32:0]        prod_x_q, prod_y_q;
	logic [34:0]        sx_q, sy_q;
	logic [8:0]         gc_q, gr_q;
	logic               hit_q;
	logic [GRID_AW-1:0] addr_q;
	logic [7:0]         rdata_q;
	res_t               res_q, out_q;
	logic               out_valid_q;
	logic               loaded_q, seen_q;

	logic [7:0]         grid_mem [GRID_CELLS];

	logic               item_acc, out_free, push, mark_c, skip_c;
	logic               mem_we;
	logic [GRID_AW-1:0] mem_waddr;
	logic [7:0]         mem_wdata;
	logic [18:0]        flat_c;
	proj_t              px_c, py_c;

	assign item_acc = item.valid && item.ready;
	assign out_free = !out_valid_q || res.ready;
	assign mark_c   = (op_q == OP_COST) && hit_q && (rdata_q != mark_q);
	assign skip_c   = ((item.op == OP_LOAD) && loaded_q) || ((item.op == OP_COST) && !loaded_q);
	assign flat_c   = 19'(gr_q) * 19'(width_q) + 19'(gc_q);
	assign px_c     = project(sx_q, width_q);
	assign py_c     = project(sy_q, height_q);

	assign cfg.ready         = 1'b1;
	assign res.valid         = out_valid_q;
	assign res.read_value    = out_q.read_value;
	assign res.marked        = out_q.marked;
	assign res.skipped       = out_q.skipped;
	assign res.frame_changed = out_q.frame_changed;

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = addr_q;
		mem_wdata  = mark_q;
		push       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					unique case (item.op)
						OP_LOAD: begin
							state_d = ST_OUT;
							if (!loaded_q) begin
								mem_we    = 1'b1;
								mem_waddr = item.global_index[GRID_AW-1:0];
								mem_wdata = item.cell_value;
							end
						end
						OP_COST: state_d = loaded_q ? ST_MUL : ST_OUT;
						OP_READ: state_d = ST_RD;
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_BND;
			ST_BND:  state_d = ST_FLAT;
			ST_FLAT: state_d = ST_RD;
			ST_RD:   state_d = ST_CHK;
			ST_CHK: begin
				state_d = ST_OUT;
				mem_we  = mark_c;
			end
			ST_OUT: begin
				if (out_free) begin
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= 1'b0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_acc && item.op == OP_LOAD && item.last)
				loaded_q <= 1'b1;
			if (item_acc && item.op == OP_COST && !loaded_q && item.last)
				seen_q <= 1'b0;
			if (state_q == ST_CHK && op_q == OP_COST) begin
				if (last_q)
					seen_q <= 1'b0;
				else if (mark_c)
					seen_q <= 1'b1;
			end
			if (push)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xoff_q   <= '0;
			yoff_q   <= '0;
			scale_q  <= SCALE_RST;
			width_q  <= DIM_RST;
			height_q <= DIM_RST;
			thr_q    <= THRESH_RST;
			mark_q   <= MARK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_X_OFFSET:    xoff_q   <= cfg.data;
				CFG_Y_OFFSET:    yoff_q   <= cfg.data;
				CFG_CELL_SCALE:  scale_q  <= cfg.data[23:0];
				CFG_GRID_WIDTH:  width_q  <= cfg.data[8:0];
				CFG_GRID_HEIGHT: height_q <= cfg.data[8:0];
				CFG_THRESHOLD:   thr_q    <= cfg.data[7:0];
				CFG_OCC_MARK:    mark_q   <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			op_q                <= item.op;
			val_q               <= item.cell_value;
			last_q              <= item.last;
			col_q               <= item.cost_col;
			row_q               <= item.cost_row;
			addr_q              <= item.global_index[GRID_AW-1:0];
			res_q.read_value    <= '0;
			res_q.marked        <= 1'b0;
			res_q.skipped       <= skip_c;
			res_q.frame_changed <= 1'b0;
		end
		unique case (state_q)
			ST_MUL: begin
				prod_x_q <= 33'({col_q, 1'b1}) * 33'(scale_q);
				prod_y_q <= 33'({row_q, 1'b1}) * 33'(scale_q);
			end
			ST_ADD: begin
				sx_q <= {{2{xoff_q[31]}}, xoff_q, 1'b0} + {2'b00, prod_x_q};
				sy_q <= {{2{yoff_q[31]}}, yoff_q, 1'b0} + {2'b00, prod_y_q};
			end
			ST_BND: begin
				gc_q  <= px_c.coord;
				gr_q  <= py_c.coord;
				hit_q <= px_c.hit && py_c.hit && (val_q >= thr_q);
			end
			ST_FLAT: addr_q <= flat_c[GRID_AW-1:0];
			ST_CHK: begin
				res_q.read_value    <= (op_q == OP_READ) ? rdata_q : '0;
				res_q.marked        <= mark_c;
				res_q.frame_changed <= (op_q == OP_COST) && last_q && (seen_q || mark_c);
			end
			ST_IDLE, ST_RD, ST_OUT: ;
		endcase
		if (push)
			out_q <= res_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			grid_mem[mem_waddr] <= mem_wdata;
		rdata_q <= grid_mem[addr_q];
	end

endmodule

>>> hw/rtl/ogom_check.sv
`include "assert_macros.svh"

module ogom_check (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_read_value,
	input logic       res_marked,
	input logic       res_skipped,
	input logic       res_frame_changed
);

	logic [10:0] res_word;
	logic        res_change;

	assign res_word   = {res_read_value, res_marked, res_skipped, res_frame_changed};
	assign res_change = res_marked || res_frame_changed;

	`OGOM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result word dropped")

	`OGOM_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_word), "stalled word changed")

	`OGOM_ASSERT_NEXT(a_one_item, item_valid && item_ready, !item_ready, "second word taken while busy")

	`OGOM_ASSERT(a_skip_excl, (res_valid && res_skipped) |-> !res_change, "skipped word changed")

	`OGOM_ASSERT(a_mark_noread, (res_valid && res_marked) |-> (res_read_value == 8'd0), "mark with data")

endmodule

bind occupancy_grid_obstacle_merge_top ogom_check u_ogom_check (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_read_value    (res.read_value),
	.res_marked        (res.marked),
	.res_skipped       (res.skipped),
	.res_frame_changed (res.frame_changed)
);

>>> sim/ogom_checker.sv
`timescale 1ns / 100ps

module ogom_checker import ogom_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ogom_item_if item,
	ogom_res_if  res,
	ogom_cfg_if  cfg,
	output int   fail_count,
	output logic drained
);

	typedef struct packed {
		logic       hit;
		logic [8:0] coord;
	} axis_t;

	logic signed [7:0]  grid [GRID_CELLS];
	logic               map_loaded;
	logic               frame_seen;
	logic signed [31:0] x_off;
	logic signed [31:0] y_off;
	logic [23:0]        scale;
	logic [8:0]         width;
	logic [8:0]         height;
	logic signed [7:0]  threshold;
	logic signed [7:0]  mark;
	res_t               cell_results_q [$];

	function automatic axis_t project_axis(input logic signed [31:0] off, input logic [7:0] pos,
		input logic [23:0] sc, input logic [8:0] limit);
		longint s;
		longint q;
		axis_t  a;
		s = 2 * longint'(off) + longint'(2 * int'(pos) + 1) * longint'(sc);
		q = ((s < 0) ? -s : s) >> 17;
		a.coord = q[8:0];
		a.hit = !(s < 0 && q != 0) && (q < longint'(limit));
		return a;
	endfunction

	function automatic res_t merge_word(input logic [1:0] op, input logic signed [7:0] value,
		input logic [15:0] gidx, input logic [7:0] col, input logic [7:0] row,
		input logic last);
		res_t        r;
		axis_t       ax;
		axis_t       ay;
		int          flat_full;
		logic [15:0] flat;
		r = '0;
		case (op)
		OP_LOAD: begin
			if (map_loaded) begin
				r.skipped = 1'b1;
			end else begin
				grid[gidx] = value;
				if (last) begin
					map_loaded = 1'b1;
				end
			end
		end
		OP_COST: begin
			if (!map_loaded) begin
				r.skipped = 1'b1;
			end else begin
				ax = project_axis(x_off, col, scale, width);
				ay = project_axis(y_off, row, scale, height);
				if (value >= threshold && ax.hit && ay.hit) begin
					flat_full = int'(ay.coord) * int'(width) + int'(ax.coord);
					flat = flat_full[15:0];
					if (grid[flat] != mark) begin
						grid[flat] = mark;
						r.marked = 1'b1;
						frame_seen = 1'b1;
					end
				end
				if (last) begin
					r.frame_changed = frame_seen;
				end
			end
			if (last) begin
				frame_seen = 1'b0;
			end
		end
		OP_READ: r.read_value = grid[gidx];
		default: r = '0;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			map_loaded = 1'b0;
			frame_seen = 1'b0;
			x_off = '0;
			y_off = '0;
			scale = SCALE_RST;
			width = DIM_RST;
			height = DIM_RST;
			threshold = THRESH_RST;
			mark = MARK_RST;
			cell_results_q.delete();
			fail_count <= 0;
			drained <= 1'b1;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_X_OFFSET:    x_off = cfg.data;
				CFG_Y_OFFSET:    y_off = cfg.data;
				CFG_CELL_SCALE:  scale = cfg.data[23:0];
				CFG_GRID_WIDTH:  width = cfg.data[8:0];
				CFG_GRID_HEIGHT: height = cfg.data[8:0];
				CFG_THRESHOLD:   threshold = cfg.data[7:0];
				CFG_OCC_MARK:    mark = cfg.data[7:0];
				default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				cell_results_q.push_back(merge_word(item.op, item.cell_value, item.global_index,
					item.cost_col, item.cost_row, item.last));
			end
			if (res.valid && res.ready) begin
				got = {res.read_value, res.marked, res.skipped, res.frame_changed};
				if (cell_results_q.size() == 0) begin
					fail_count <= fail_count + 1;
					$display("%0t: result word with none expected: read_value=%0d marked=%0b",
						$time, got.read_value, got.marked,
						" skipped=%0b frame_changed=%0b", got.skipped, got.frame_changed);
				end else begin
					want = cell_results_q.pop_front();
					if (got !== want) begin
						fail_count <= fail_count + 1;
						$display("%0t: expected read_value=%0d marked=%0b skipped=%0b",
							$time, want.read_value, want.marked, want.skipped,
							" frame_changed=%0b, actual read_value=%0d marked=%0b",
							want.frame_changed, got.read_value, got.marked,
							" skipped=%0b frame_changed=%0b", got.skipped,
							got.frame_changed);
					end
				end
			end
			drained <= (cell_results_q.size() == 0);
		end
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ogom_pkg::*;

	localparam int         STALL_LIMIT   = 4000;
	localparam int         SETTLE_CYCLES = 16;
	localparam int         PHASE_WORDS   = 85;
	localparam int         LOAD_CELLS    = 256;
	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	int                src_idle_pct = 0;
	int                dst_stall_pct = 0;
	int                stall_cycles = 0;
	int                fail_count;
	logic              drained;
	logic signed [7:0] cur_threshold = THRESH_RST;
	int                n_load = 0;
	int                n_cost = 0;
	int                n_read = 0;
	int                n_other = 0;
	int                n_settings = 0;
	int                src_prof [4] = '{0, 84, 0, 20};
	int                dst_prof [4] = '{0, 0, 84, 20};

	ogom_item_if item_bus ();
	ogom_res_if  res_bus ();
	ogom_cfg_if  cfg_bus ();

	occupancy_grid_obstacle_merge_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	ogom_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_bus),
		.res        (res_bus),
		.cfg        (cfg_bus),
		.fail_count (fail_count),
		.drained    (drained)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		res_bus.ready <= ($urandom_range(99) >= dst_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
			(cfg_bus.valid && cfg_bus.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no word accepted in %0d cycles", $time, STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_word(input logic [1:0] op, input logic [7:0] value,
		input logic [15:0] gidx, input logic [7:0] col, input logic [7:0] row,
		input logic last);
		if ($urandom_range(99) < src_idle_pct) begin
			item_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		item_bus.valid        <= 1'b1;
		item_bus.op           <= op;
		item_bus.cell_value   <= value;
		item_bus.global_index <= gidx;
		item_bus.cost_col     <= col;
		item_bus.cost_row     <= row;
		item_bus.last         <= last;
		do @(posedge clk); while (!item_bus.ready);
		case (op)
		OP_LOAD: n_load++;
		OP_COST: n_cost++;
		OP_READ: n_read++;
		default: n_other++;
		endcase
	endtask

	task automatic wait_drained();
		item_bus.valid <= 1'b0;
		do @(posedge clk); while (!drained);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	task automatic apply_settings(input logic [31:0] xo, input logic [31:0] yo,
		input logic [23:0] sc, input logic [8:0] w, input logic [8:0] h,
		input logic [7:0] thr, input logic [7:0] mk);
		wait_drained();
		write_reg(CFG_UNUSED, $urandom);
		write_reg(CFG_X_OFFSET, xo);
		write_reg(CFG_Y_OFFSET, yo);
		write_reg(CFG_CELL_SCALE, {8'h00, sc});
		write_reg(CFG_GRID_WIDTH, {23'd0, w});
		write_reg(CFG_GRID_HEIGHT, {23'd0, h});
		write_reg(CFG_THRESHOLD, {{24{thr[7]}}, thr});
		write_reg(CFG_OCC_MARK, {{24{mk[7]}}, mk});
		cfg_bus.valid <= 1'b0;
		cur_threshold = thr;
		n_settings++;
	endtask

	task automatic run_phase(input int words);
		int         pick;
		logic [7:0] cost;
		logic [7:0] col;
		logic [7:0] row;
		src_idle_pct = src_prof[(n_settings - 1) % 4];
		dst_stall_pct = dst_prof[(n_settings - 1) % 4];
		repeat (words) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				if ($urandom_range(1) == 0) begin
					cost = 8'($urandom);
				end else begin
					cost = 8'(int'(cur_threshold) + int'($urandom_range(127 - int'(cur_threshold))));
				end
				if ($urandom_range(3) == 0) begin
					col = 8'($urandom_range(7));
					row = 8'($urandom_range(7));
				end else begin
					col = 8'($urandom);
					row = 8'($urandom);
				end
				send_word(OP_COST, cost, 16'($urandom), col, row, $urandom_range(11) == 0);
			end else if (pick < 88) begin
				send_word(OP_READ, 8'($urandom), 16'($urandom_range(LOAD_CELLS - 1)),
					8'($urandom), 8'($urandom), 1'($urandom_range(1)));
			end else if (pick < 95) begin
				send_word(OP_LOAD, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
					1'($urandom_range(1)));
			end else begin
				send_word(OP_UNUSED, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
					1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		logic [7:0] load_value;
		item_bus.valid        <= 1'b0;
		item_bus.op           <= OP_LOAD;
		item_bus.cell_value   <= '0;
		item_bus.global_index <= '0;
		item_bus.cost_col     <= '0;
		item_bus.cost_row     <= '0;
		item_bus.last         <= 1'b0;
		cfg_bus.valid         <= 1'b0;
		cfg_bus.index         <= CFG_X_OFFSET;
		cfg_bus.data          <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 20;
		dst_stall_pct = 20;
		send_word(OP_COST, 8'h7F, 16'h0000, 8'h00, 8'h00, 1'b0);
		send_word(OP_COST, 8'h80, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
		send_word(OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
		send_word(OP_UNUSED, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);

		src_idle_pct = 0;
		dst_stall_pct = 0;
		for (int i = 0; i < LOAD_CELLS; i++) begin
			if (i > 0 && $urandom_range(15) == 0) begin
				send_word(OP_READ, 8'($urandom), 16'($urandom_range(i - 1)), 8'($urandom),
					8'($urandom), 1'($urandom_range(1)));
			end
			if ($urandom_range(15) == 0) begin
				send_word(OP_COST, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
					1'($urandom_range(1)));
			end
			if (i == 0) begin
				load_value = 8'h80;
			end else if (i == LOAD_CELLS - 1) begin
				load_value = 8'h7F;
			end else if ($urandom_range(3) == 0) begin
				load_value = MARK_RST;
			end else begin
				load_value = 8'($urandom);
			end
			send_word(OP_LOAD, load_value, 16'(i), 8'($urandom), 8'($urandom),
				i == LOAD_CELLS - 1);
		end
		send_word(OP_LOAD, 8'h55, 16'h0000, 8'h00, 8'h00, 1'b0);
		send_word(OP_LOAD, 8'hAA, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
		send_word(OP_READ, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
		send_word(OP_READ, 8'hFF, 16'(LOAD_CELLS - 1), 8'hFF, 8'hFF, 1'b1);

		apply_settings(32'h0, 32'h0, SCALE_RST, DIM_RST, DIM_RST, THRESH_RST, MARK_RST);
		send_word(OP_COST, 8'd65, 16'h0000, 8'd0, 8'd0, 1'b0);
		send_word(OP_COST, 8'd64, 16'h0000, 8'd1, 8'd0, 1'b0);
		send_word(OP_COST, 8'h7F, 16'h0000, 8'd255, 8'd0, 1'b1);
		send_word(OP_COST, 8'h7F, 16'h0000, 8'd0, 8'd0, 1'b1);
		send_word(OP_COST, 8'h80, 16'h0000, 8'd255, 8'd0, 1'b1);
		send_word(OP_READ, 8'h00, 16'h0000, 8'd0, 8'd0, 1'b0);
		send_word(OP_READ, 8'h00, 16'(LOAD_CELLS - 1), 8'd0, 8'd0, 1'b0);

		apply_settings(32'h0, 32'h0, SCALE_RST, 9'd16, 9'd16, THRESH_RST, MARK_RST);
		run_phase(PHASE_WORDS);
		apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 9'd511, 9'd0, 8'h80, 8'h80);
		run_phase(PHASE_WORDS);
		apply_settings(32'h0003_0000, -32'sh0002_8000, 24'd32768, 9'd20, 9'd12, 8'h00, 8'h7F);
		run_phase(PHASE_WORDS);
		apply_settings(32'hFFFF_FFFF, 32'h0, 24'd1, 9'd1, 9'd1, 8'h7F, 8'h00);
		run_phase(PHASE_WORDS);
		apply_settings(32'h0, 32'h0000_8000, 24'hFF_FFFF, 9'd0, 9'd511, 8'h00, 8'h7F);
		run_phase(PHASE_WORDS);
		apply_settings(32'h0002_0000, 32'h0001_0000, 24'd131072, 9'd32, 9'd8, 8'd50, 8'hFF);
		run_phase(PHASE_WORDS);
		repeat (4) begin
			apply_settings($urandom_range(32'h40_0000) - 32'h20_0000,
				$urandom_range(32'h40_0000) - 32'h20_0000, 24'($urandom_range(196608, 16384)),
				9'($urandom_range(16, 1)), 9'($urandom_range(16, 1)), 8'($urandom),
				8'($urandom));
			run_phase(PHASE_WORDS);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d map loads, %0d costmap cells, %0d reads, %0d unused-op words",
			n_load, n_cost, n_read, n_other);
		$display("across %0d register settings and four idle/stall profiles", n_settings);
		if (fail_count == 0 && drained) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ogom_pkg.sv
hw/rtl/ogom_if.sv
hw/rtl/occupancy_grid_obstacle_merge_top.sv
hw/rtl/ogom_check.sv
sim/ogom_checker.sv
sim/tb_top.sv
